@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the reply frame parser.
// Depends on nothing; included by the modules that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/arfp_pkg.sv @@
// Package for the ASCII reply frame parser: sizes, codes, result type.
// Depends on nothing.
package arfp_pkg;

    localparam int RX_BUFFER_BYTES = 64;
    localparam int TEXT_MAX_CHARS  = 7;
    localparam int LEN_W           = 7;
    localparam int TXT_W           = 4;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_DISC = 2'd1;
    localparam logic [1:0] KIND_POLL = 2'd2;

    localparam logic [7:0] CH_OPEN  = 8'h3C;
    localparam logic [7:0] CH_CLOSE = 8'h3E;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef struct packed {
        logic [1:0]  reply_kind;
        logic [7:0]  node_addr;
        logic [7:0]  device_addr;
        logic [15:0] mask_value;
        logic [15:0] message_number;
        logic        flag_bit;
    } reply_t;

endpackage

@@ rtl/arfp_front.sv @@
// Front part: consumes one byte a cycle, parses the frame, emits a reply.
// Depends on arfp_pkg.
module arfp_front
    import arfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    output logic       rep_valid,
    output reply_t     rep
);

    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        PH_IDLE, PH_TYPE, PH_PRE1, PH_NUM1, PH_PRE2, PH_NUM2, PH_PRE3, PH_NUM3,
        PH_PRETEXT, PH_TEXT, PH_DEAD, PH_READY
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [1:0]        type_reg, type_next;
    logic [15:0]       acc_reg, acc_next;
    logic [15:0]       first_reg, first_next;
    logic [7:0]        second_reg, second_next;
    logic [TXT_W-1:0]  tprog_reg, tprog_next;
    logic              tmatch_reg, tmatch_next;
    logic              rep_valid_next;
    reply_t            rep_next;

    logic [7:0] c;
    logic       blank, digit, stored;
    logic [15:0] acc_dig;
    logic [3:0]  digval;

    function automatic logic [7:0] word_char(input logic [1:0] kind,
                                             input logic [TXT_W-1:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (kind == KIND_ACK) begin
            case (idx)
                4'd0: ch = "O";
                4'd1: ch = "K";
                default: ch = 8'h00;
            endcase
        end else begin
            case (idx)
                4'd0: ch = "t";
                4'd1: ch = "r";
                4'd2: ch = "u";
                4'd3: ch = "e";
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

    always_comb begin
        logic [TXT_W-1:0] wlen;
        logic             do_finish;
        c       = in_byte;
        blank   = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
        digit   = (c >= 8'd48) && (c <= 8'd57);
        digval  = c[3:0];
        acc_dig = 16'((acc_reg << 3) + (acc_reg << 1) + {12'd0, digval});
        stored  = len_reg < LEN_W'(RX_BUFFER_BYTES - 1);
        wlen    = (type_reg == KIND_ACK) ? TXT_W'(2) : TXT_W'(4);

        phase_next     = phase_reg;
        len_next       = len_reg;
        type_next      = type_reg;
        acc_next       = acc_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        tprog_next     = tprog_reg;
        tmatch_next    = tmatch_reg;
        rep_valid_next = 1'b0;
        rep_next       = '0;
        do_finish      = 1'b0;

        if (in_valid) begin
            if (c == CH_OPEN) begin
                len_next    = LEN_W'(1);
                phase_next  = PH_TYPE;
                type_next   = KIND_ACK;
                acc_next    = '0;
                first_next  = '0;
                second_next = '0;
                tprog_next  = '0;
                tmatch_next = 1'b0;
            end else if (phase_reg != PH_IDLE) begin
                if (stored)
                    len_next = len_reg + LEN_W'(1);
                do_finish = (c == CH_CLOSE) || !stored || (c == 8'd0);
                if (!do_finish) begin
                    // feed one content byte
                    case (phase_reg)
                        PH_TYPE: begin
                            phase_next = PH_PRE1;
                            if (c == "a") type_next = KIND_ACK;
                            else if (c == "d") type_next = KIND_DISC;
                            else if (c == "r") type_next = KIND_POLL;
                            else phase_next = PH_DEAD;
                        end
                        PH_PRE1, PH_PRE2, PH_PRE3: begin
                            if (digit) begin
                                acc_next = {12'd0, digval};
                                phase_next = phase_t'(phase_reg + 4'd1);
                            end else if (!blank) begin
                                phase_next = PH_DEAD;
                            end
                        end
                        PH_NUM1, PH_NUM2: begin
                            if (digit) begin
                                acc_next = acc_dig;
                            end else begin
                                if (phase_reg == PH_NUM1) first_next = acc_reg;
                                else second_next = acc_reg[7:0];
                                if ((phase_reg == PH_NUM1 && type_reg == KIND_ACK) ||
                                    (phase_reg == PH_NUM2 && type_reg == KIND_DISC)) begin
                                    if (blank) begin
                                        phase_next = PH_PRETEXT;
                                    end else begin
                                        phase_next  = PH_TEXT;
                                        tprog_next  = TXT_W'(1);
                                        tmatch_next = (c == word_char(type_reg, '0));
                                    end
                                end else if (blank) begin
                                    phase_next = phase_t'(phase_reg + 4'd1);
                                end else begin
                                    phase_next = PH_DEAD;
                                end
                            end
                        end
                        PH_NUM3: begin
                            if (digit) begin
                                acc_next = acc_dig;
                            end else begin
                                tmatch_next = 1'b0;
                                phase_next  = PH_READY;
                            end
                        end
                        PH_PRETEXT: begin
                            if (!blank) begin
                                phase_next  = PH_TEXT;
                                tprog_next  = TXT_W'(1);
                                tmatch_next = (c == word_char(type_reg, '0));
                            end
                        end
                        PH_TEXT: begin
                            if (tprog_reg < TXT_W'(TEXT_MAX_CHARS)) begin
                                if (tprog_reg >= wlen || c != word_char(type_reg, tprog_reg))
                                    tmatch_next = 1'b0;
                                tprog_next = tprog_reg + TXT_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end else begin
                    case (phase_reg)
                        PH_NUM1: begin
                            first_next = acc_reg;
                            if (type_reg == KIND_ACK) begin
                                tmatch_next = 1'b1;
                                phase_next  = PH_READY;
                            end else begin
                                phase_next = PH_DEAD;
                            end
                        end
                        PH_NUM3: begin
                            tmatch_next = 1'b0;
                            phase_next  = PH_READY;
                        end
                        PH_PRETEXT: begin
                            if (type_reg == KIND_ACK) begin
                                tmatch_next = 1'b1;
                                phase_next  = PH_READY;
                            end else begin
                                phase_next = PH_DEAD;
                            end
                        end
                        PH_TEXT: begin
                            tmatch_next = tmatch_reg && (tprog_reg == wlen);
                            phase_next  = PH_READY;
                        end
                        PH_READY, PH_DEAD, PH_IDLE: ;
                        default: phase_next = PH_DEAD;
                    endcase
                end
                if (c == CH_CLOSE) begin
                    if (phase_next == PH_READY) begin
                        rep_valid_next      = 1'b1;
                        rep_next.reply_kind = type_reg;
                        rep_next.node_addr  = (type_reg == KIND_ACK) ? 8'd0 : first_next[7:0];
                        rep_next.device_addr = (type_reg == KIND_ACK) ? 8'd0 : second_next;
                        rep_next.mask_value = (type_reg == KIND_POLL) ? acc_next : 16'd0;
                        rep_next.message_number = (type_reg == KIND_ACK) ? first_next : 16'd0;
                        rep_next.flag_bit   = (type_reg == KIND_POLL) ? 1'b0 : tmatch_next;
                    end
                    phase_next = PH_IDLE;
                    len_next   = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg  <= PH_IDLE;
            len_reg    <= '0;
            type_reg   <= KIND_ACK;
            acc_reg    <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            tprog_reg  <= '0;
            tmatch_reg <= 1'b0;
            rep_valid  <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            type_reg   <= type_next;
            acc_reg    <= acc_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            tprog_reg  <= tprog_next;
            tmatch_reg <= tmatch_next;
            rep_valid  <= rep_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        rep <= rep_next;
    end

    `ASSERT_IMPL(a_len_bound, clk, rst_n, 1'b1,
        len_reg <= LEN_W'(RX_BUFFER_BYTES - 1), "frame length past buffer")
    `ASSERT_IMPL(a_idle_len, clk, rst_n, phase_reg == PH_IDLE,
        len_reg == '0, "idle with nonzero length")
    `ASSERT_IMPL(a_rep_kind, clk, rst_n, rep_valid,
        rep.reply_kind != 2'd3, "bad reply kind")

endmodule

@@ rtl/arfp_queue.sv @@
// Short result queue between the parser and the result port.
// Depends on arfp_pkg.
module arfp_queue
    import arfp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  reply_t wr_data,
    input  logic   rd_en,
    output logic   empty,
    output logic   almost_full,
    output reply_t rd_data
);

    `include "assert_macros.svh"

    reply_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign empty       = (count_reg == '0);
    assign almost_full = (count_reg != '0);
    assign rd_data     = mem[rptr_reg];

    always_ff @(posedge clk) begin
        if (wr_en)
            mem[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (wr_en)
                wptr_reg <= wptr_reg + QPTR_W'(1);
            if (rd_en)
                rptr_reg <= rptr_reg + QPTR_W'(1);
            count_reg <= count_reg + (QPTR_W+1)'(wr_en) - (QPTR_W+1)'(rd_en);
        end
    end

    `ASSERT_IMPL(a_no_overflow, clk, rst_n, count_reg == (QPTR_W+1)'(QUEUE_DEPTH),
        !wr_en || rd_en, "result queue overflow")
    `ASSERT_IMPL(a_no_underflow, clk, rst_n, rd_en, !empty, "result queue underflow")

endmodule

@@ rtl/ascii_reply_frame_parser.sv @@
// Top level of the ASCII reply frame parser: byte queue in, reply queue out.
// Depends on arfp_pkg, arfp_front, arfp_queue.
// One byte is taken per cycle while full is low. A reply reaches the result ports
// through the parser register, then a two-entry result queue. full rises while a
// reply is queued and not popped or another waits in the parser register, so a slow
// reader holds the byte stream; with pop kept high the parser takes a byte every cycle.
module ascii_reply_frame_parser
    import arfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  reply_kind,
    output logic [7:0]  node_addr,
    output logic [7:0]  device_addr,
    output logic [15:0] mask_value,
    output logic [15:0] message_number,
    output logic        flag_bit
);

    logic   rep_valid, q_af, q_empty;
    reply_t rep, q_data;

    // a reply may still sit in the parser register, so stop while the queue is busy
    assign full = q_af && !(pop && !q_empty) || (q_af && rep_valid);

    arfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push && !full),
        .in_byte   (rx_byte),
        .rep_valid (rep_valid),
        .rep       (rep)
    );

    arfp_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (rep_valid),
        .wr_data     (rep),
        .rd_en       (pop && !q_empty),
        .empty       (q_empty),
        .almost_full (q_af),
        .rd_data     (q_data)
    );

    assign empty          = q_empty;
    assign reply_kind     = q_data.reply_kind;
    assign node_addr      = q_data.node_addr;
    assign device_addr    = q_data.device_addr;
    assign mask_value     = q_data.mask_value;
    assign message_number = q_data.message_number;
    assign flag_bit       = q_data.flag_bit;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the ASCII reply frame parser.
// Depends on arfp_pkg and ascii_reply_frame_parser; a scoreboard class predicts the
// replies from the pushed bytes and checks every popped reply against the oldest one.
module testbench;
    import arfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    localparam logic [7:0] CH_ACK  = 8'h61;   // 'a'
    localparam logic [7:0] CH_DISC = 8'h64;   // 'd'
    localparam logic [7:0] CH_POLL = 8'h72;   // 'r'

    typedef enum logic [3:0] {
        PH_IDLE, PH_TYPE, PH_PRE1, PH_NUM1, PH_PRE2, PH_NUM2,
        PH_PRE3, PH_NUM3, PH_PRETEXT, PH_TEXT, PH_DEAD, PH_READY
    } phase_t;

    class reply_scoreboard;
        reply_t      pending_replies[$];
        int          errors;
        int          mismatches;
        int          frame_len;
        phase_t      ph;
        logic [1:0]  ftype;
        logic [15:0] accum;
        logic [15:0] first_num;
        logic [7:0]  second_num;
        int          text_cnt;
        bit          text_ok;

        function bit is_blank(logic [7:0] c);
            return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= 8'd48 && c <= 8'd57;
        endfunction

        function void add_digit(logic [7:0] c);
            accum = 16'(accum * 16'd10 + 16'(c - 8'd48));
        endfunction

        function void text_char(logic [7:0] c);
            logic [7:0] want;
            int         wlen;
            wlen = (ftype == KIND_ACK) ? 2 : 4;
            if (text_cnt >= TEXT_MAX_CHARS)
                return;
            if (ftype == KIND_ACK)
                want = (text_cnt == 0) ? 8'h4F : 8'h4B;
            else
                case (text_cnt)
                    0: want = 8'h74;
                    1: want = 8'h72;
                    2: want = 8'h75;
                    default: want = 8'h65;
                endcase
            if (text_cnt >= wlen || c != want)
                text_ok = 0;
            text_cnt++;
        endfunction

        function void start_text(logic [7:0] c);
            text_cnt = 0;
            text_ok = 1;
            ph = PH_TEXT;
            text_char(c);
        endfunction

        function void parse_char(logic [7:0] c);
            case (ph)
                PH_TYPE:
                    if (c == CH_ACK) begin ftype = KIND_ACK; ph = PH_PRE1; end
                    else if (c == CH_DISC) begin ftype = KIND_DISC; ph = PH_PRE1; end
                    else if (c == CH_POLL) begin ftype = KIND_POLL; ph = PH_PRE1; end
                    else ph = PH_DEAD;
                PH_PRE1, PH_PRE2, PH_PRE3:
                    if (is_digit(c))
                    begin
                        accum = '0;
                        add_digit(c);
                        ph = phase_t'(ph + 1);
                    end
                    else if (!is_blank(c))
                        ph = PH_DEAD;
                PH_NUM1:
                    if (is_digit(c))
                        add_digit(c);
                    else
                    begin
                        first_num = accum;
                        if (ftype == KIND_ACK)
                        begin
                            if (is_blank(c)) ph = PH_PRETEXT;
                            else start_text(c);
                        end
                        else
                            ph = is_blank(c) ? PH_PRE2 : PH_DEAD;
                    end
                PH_NUM2:
                    if (is_digit(c))
                        add_digit(c);
                    else
                    begin
                        second_num = accum[7:0];
                        if (ftype == KIND_DISC)
                        begin
                            if (is_blank(c)) ph = PH_PRETEXT;
                            else start_text(c);
                        end
                        else
                            ph = is_blank(c) ? PH_PRE3 : PH_DEAD;
                    end
                PH_NUM3:
                    if (is_digit(c))
                        add_digit(c);
                    else
                    begin
                        text_ok = 0;
                        ph = PH_READY;
                    end
                PH_PRETEXT:
                    if (!is_blank(c)) start_text(c);
                PH_TEXT:
                    text_char(c);
                default: ;
            endcase
        endfunction

        // content over (close, overflow or zero byte): decide if a reply forms
        function void end_content();
            case (ph)
                PH_NUM1:
                begin
                    first_num = accum;
                    if (ftype == KIND_ACK) begin text_ok = 1; ph = PH_READY; end
                    else ph = PH_DEAD;
                end
                PH_NUM3:
                begin
                    text_ok = 0;
                    ph = PH_READY;
                end
                PH_PRETEXT:
                    if (ftype == KIND_ACK) begin text_ok = 1; ph = PH_READY; end
                    else ph = PH_DEAD;
                PH_TEXT:
                begin
                    text_ok = text_ok && text_cnt == ((ftype == KIND_ACK) ? 2 : 4);
                    ph = PH_READY;
                end
                PH_READY, PH_DEAD, PH_IDLE: ;
                default: ph = PH_DEAD;
            endcase
        endfunction

        function void note_byte(logic [7:0] c);
            bit     stored;
            reply_t r;
            if (c == CH_OPEN)
            begin
                frame_len = 1;
                ph = PH_TYPE;
                ftype = KIND_ACK;
                accum = '0;
                first_num = '0;
                second_num = '0;
                text_cnt = 0;
                text_ok = 0;
                return;
            end
            if (ph == PH_IDLE)
                return;
            stored = frame_len < RX_BUFFER_BYTES - 1;
            if (stored)
                frame_len++;
            if (c == CH_CLOSE)
            begin
                end_content();
                if (ph == PH_READY)
                begin
                    r.reply_kind     = ftype;
                    r.node_addr      = (ftype == KIND_ACK) ? 8'd0 : first_num[7:0];
                    r.device_addr    = (ftype == KIND_ACK) ? 8'd0 : second_num;
                    r.mask_value     = (ftype == KIND_POLL) ? accum : 16'd0;
                    r.message_number = (ftype == KIND_ACK) ? first_num : 16'd0;
                    r.flag_bit       = (ftype == KIND_POLL) ? 1'b0 : text_ok;
                    pending_replies.push_back(r);
                end
                ph = PH_IDLE;
                frame_len = 0;
                return;
            end
            if (!stored || c == 8'd0)
                end_content();
            else
                parse_char(c);
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (pending_replies.size() == 0)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply %p", got);
                return;
            end
            want = pending_replies.pop_front();
            if (got.reply_kind !== want.reply_kind || got.node_addr !== want.node_addr ||
                got.device_addr !== want.device_addr || got.mask_value !== want.mask_value ||
                got.message_number !== want.message_number || got.flag_bit !== want.flag_bit)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("reply mismatch: expected %p, got %p", want, got);
            end
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        push = 0;
    logic        full;
    logic [7:0]  rx_byte = 0;
    logic        empty;
    logic        pop = 0;
    logic [1:0]  reply_kind;
    logic [7:0]  node_addr;
    logic [7:0]  device_addr;
    logic [15:0] mask_value;
    logic [15:0] message_number;
    logic        flag_bit;
    reply_t      got_reply;

    reply_scoreboard sb = new();
    int  send_idle = 0;
    int  recv_idle = 0;
    logic hold = 0;
    int  bytes_sent = 0;
    int  stall_cnt = 0;

    ascii_reply_frame_parser dut (.*);

    assign got_reply = {reply_kind, node_addr, device_addr, mask_value, message_number,
                        flag_bit};

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_byte(rx_byte);
            if (pop && !empty)
                sb.check_reply(got_reply);
            if ((push && !full) || (pop && !empty))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            pop <= !hold && ($urandom_range(99) >= recv_idle);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 0;
            @(posedge clk);
        end
        push <= 1;
        rx_byte <= b;
        do @(posedge clk); while (full);
        bytes_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic drain_replies();
        push <= 0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    function automatic void add_blanks(ref logic [7:0] q[$], input int lo, input int hi);
        logic [7:0] blanks[6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
        int n;
        n = $urandom_range(hi, lo);
        repeat (n) q.push_back(blanks[$urandom_range(5)]);
    endfunction

    function automatic void add_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endfunction

    // mostly well-formed frames with random content; some broken, noise or overlong
    function automatic void make_frame(ref logic [7:0] q[$], input bit clean);
        string ack_words[5]  = '{"OK", "ok", "OKAY", "O", "OK "};
        string disc_words[5] = '{"true", "false", "tru", "true ", "TRUE"};
        int sel;
        int kind;
        int pos;
        sel = clean ? 99 : $urandom_range(99);
        q = {};
        if (sel < 5)
        begin
            repeat ($urandom_range(10, 1)) q.push_back(8'($urandom_range(255)));
            return;
        end
        q.push_back(CH_OPEN);
        kind = $urandom_range(2);
        q.push_back(kind == 0 ? CH_ACK : kind == 1 ? CH_DISC : CH_POLL);
        for (int i = 0; i <= kind; i++)
        begin
            add_blanks(q, (i == 0) ? 0 : 1, 2);
            add_text(q, $sformatf("%0d", $urandom_range(1) ? $urandom_range(255)
                                                          : $urandom_range(99999)));
        end
        if (kind == 0 && $urandom_range(1))
        begin
            add_blanks(q, 0, 2);
            add_text(q, $urandom_range(1) ? "OK" : ack_words[$urandom_range(4)]);
        end
        else if (kind == 1)
        begin
            add_blanks(q, 1, 2);
            add_text(q, $urandom_range(1) ? "true" : disc_words[$urandom_range(4)]);
        end
        else if (kind == 2 && $urandom_range(3) == 0)
            add_text(q, " x9");
        if (sel >= 5 && sel < 10)
            repeat ($urandom_range(70, 40)) q.push_back(8'($urandom_range(126, 32)));
        if (sel >= 10 && sel < 22)
        begin
            pos = $urandom_range(q.size() - 1, 1);
            case ($urandom_range(2))
                0: q[pos] = 8'($urandom_range(255));
                1: q.delete(pos);
                default: q.insert(pos, $urandom_range(1) ? 8'h2B : 8'h2D);
            endcase
        end
        q.push_back(CH_CLOSE);
    endfunction

    task automatic send_frame(input bit clean);
        logic [7:0] q[$];
        make_frame(q, clean);
        foreach (q[i])
            send_byte(q[i]);
    endtask

    initial
    begin
        int waited;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_idle = 28;
        recv_idle = 74;
        send_str(">zz<a12>");
        send_str("<a65535 OK><a70000\tok><a7OK><a3   >");
        send_str("<d1 2 true><d255 255 false><d1 2><d1 2\ttruexyzabc>");
        send_str("<r1 2 65535><r0 0 0 junk><r1 2><r1 2 3");
        send_str(">");
        send_str("<a-1><r+1 2 3><A1><x1><a1<a2 OK>");
        send_str("<a5");
        send_byte(8'd0);
        send_str("zz>");
        send_str("<d9 8 ");
        repeat (60) send_byte(8'hFF);
        send_str(">");
        send_str("<a4 ");
        repeat (70) send_byte(8'h80);
        send_str(">");

        while (bytes_sent < 380)
            send_frame(0);
        send_idle = 74;
        recv_idle = 28;
        while (bytes_sent < 720)
            send_frame(0);
        send_idle = 0;
        recv_idle = 0;
        drain_replies();
        // long reader stall while frames keep coming in
        hold <= 1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge clk);
                hold <= 0;
            end
        join_none
        repeat (6) send_frame(1);
        drain_replies();
        while (bytes_sent < 1050)
            send_frame(0);
        push <= 0;

        waited = 0;
        while (sb.pending() != 0 && waited < STALL_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
            sb.errors++;
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
